[hdl/sobel_edge_magnitude_3x3_macros.svh]
// Assertion macros for the Sobel edge magnitude design files (used by sem_ctrl)
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH

// Same-cycle implication under synchronous active-low reset
`define SEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sobel edge magnitude: check failed");

// Next-cycle implication under synchronous active-low reset
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobel edge magnitude: check failed");

`endif

[hdl/sem_pkg.sv]
// Types and constants shared by the Sobel edge magnitude block
package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Sums above this round to more than 255
    localparam logic [20:0] ROOT_CLAMP_LIMIT = 21'd65280;
    localparam logic [7:0]  PIX_MAX = 8'd255;

    typedef logic [23:0] t_pix;   // {blue, green, red}

    typedef struct packed {
        logic       command;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic       capture;
        logic       zero_pix;
        logic       shift;
        logic       sum;
        logic       mask_top;
        logic       mask_bot;
        logic       mask_left;
        logic       mask_right;
        logic       square;
        logic       root_step;
        logic [2:0] root_idx;
        logic       load_out;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

[hdl/sem_ctrl.sv]
// Sequencer: stream position, frame registers and step control
module sem_ctrl import sem_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_status            i_status,
    output t_dp_cmd               o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] o_addr
);
    `include "sobel_edge_magnitude_3x3_macros.svh"

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SUM, S_SQUARE, S_ROOT, S_FIN} t_state;

    t_state        r_state, n_state;
    logic [WW-1:0] r_width, n_width;
    logic [HW-1:0] r_height, n_height;
    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [2:0]    r_step, n_step;

    logic [RW:0] row_x, h_x;
    logic        emit, last, col0;
    logic [WW-1:0] col_inc;

    always_comb begin
        row_x   = (RW+1)'(r_row);
        h_x     = (RW+1)'(r_height);
        col0    = (r_col == '0);
        emit    = (row_x >= (RW+1)'(2)) || (row_x == (RW+1)'(1) && !col0);
        last    = col0 && (row_x == h_x + (RW+1)'(1));
        col_inc = WW'(r_col) + WW'(1);
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.zero_pix   = (row_x >= h_x);
        o_cmd.mask_top   = col0 ? (row_x == (RW+1)'(2)) : (row_x == (RW+1)'(1));
        o_cmd.mask_bot   = col0 ? (row_x - (RW+1)'(1) >= h_x) : (row_x >= h_x);
        o_cmd.mask_left  = (r_col == AW'(1)) || (col0 && r_width == WW'(1));
        o_cmd.mask_right = col0;
        o_cmd.root_idx   = r_step;
        o_cmd.last       = last;
        // a pending register write has priority; hold the input off meanwhile
        o_in_ready       = (r_state == S_IDLE) && !i_cfg_valid;
        o_cfg_ready      = (r_state == S_IDLE);
        o_addr           = r_col;

        n_state  = r_state;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_step   = r_step;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    // a width or height register write restarts the frame
                    n_col = '0;
                    n_row = '0;
                    if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                        if (i_cfg_data == '0) n_width = WW'(1);
                        else if (int'(i_cfg_data) > MAX_WIDTH) n_width = WW'(MAX_WIDTH);
                        else n_width = WW'(i_cfg_data);
                    end else if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                        if (i_cfg_data == '0) n_height = HW'(1);
                        else if (int'(i_cfg_data) > MAX_HEIGHT) n_height = HW'(MAX_HEIGHT);
                        else n_height = HW'(i_cfg_data);
                    end else begin
                        n_col = r_col;
                        n_row = r_row;
                    end
                end else if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (emit) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                    if (col_inc >= r_width) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                    end else begin
                        n_col = AW'(col_inc);
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_step = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                    if (last) begin
                        n_col = '0;
                        n_row = '0;
                    end else if (col_inc >= r_width) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                    end else begin
                        n_col = AW'(col_inc);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WW'(MAX_WIDTH);
            r_height <= HW'(MAX_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_step   <= n_step;
        end
    end

    `SEM_ASSERT_NOW(a_col_in_row, i_clk, i_rst_n, 1'b1, WW'(r_col) < r_width)
    `SEM_ASSERT_NOW(a_row_bound, i_clk, i_rst_n, 1'b1, row_x <= h_x + (RW+1)'(1))
    `SEM_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n,
        i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_IMAGE_WIDTH ||
        i_cfg_index == CFG_IMAGE_HEIGHT), r_row == '0 && r_col == '0)
endmodule

[hdl/sem_dp.sv]
// Datapath: line stores, 3x3 window, gradient sums, squares and rounded root
module sem_dp import sem_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  t_in_item                     i_in_item,
    output t_dp_status                   o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output t_out_item                    o_out_item
);
    t_pix r_upper_mem [MAX_WIDTH];
    t_pix r_middle_mem [MAX_WIDTH];
    t_pix r_top_rd, r_mid_rd, r_pix;
    t_pix r_win [3][3];

    logic signed [11:0] r_gx [3], r_gy [3], n_gx [3], n_gy [3];
    logic [20:0] r_sq [3], n_sq [3];
    logic [7:0]  r_root [3], n_root [3], fin [3];
    logic        r_out_valid;
    t_out_item   r_out;

    logic [7:0]  bitm;
    logic [7:0]  p [3][3];
    logic signed [23:0] sx, sy;
    logic [7:0]  t;
    logic [15:0] tt, rr;
    logic [16:0] rr1;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign bitm = 8'h80 >> i_cmd.root_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_top_rd <= r_upper_mem[i_addr];
            r_mid_rd <= r_middle_mem[i_addr];
            if (i_in_item.command == CMD_FLUSH || i_cmd.zero_pix) r_pix <= '0;
            else r_pix <= {i_in_item.in_blue, i_in_item.in_green, i_in_item.in_red};
        end
        if (i_cmd.shift) begin
            r_upper_mem[i_addr]  <= r_mid_rd;
            r_middle_mem[i_addr] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) r_win[a][b] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int a = 0; a < 3; a++) begin
                r_win[a][0] <= r_win[a][1];
                r_win[a][1] <= r_win[a][2];
            end
            r_win[0][2] <= r_top_rd;
            r_win[1][2] <= r_mid_rd;
            r_win[2][2] <= r_pix;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    p[a][b] = r_win[a][b][8*k +: 8];
                    if ((a == 0 && i_cmd.mask_top) || (a == 2 && i_cmd.mask_bot) ||
                        (b == 0 && i_cmd.mask_left) || (b == 2 && i_cmd.mask_right))
                        p[a][b] = '0;
                end
            end
            n_gx[k] = (12'($signed({4'b0, p[0][2]})) - 12'($signed({4'b0, p[0][0]})))
                    + ((12'($signed({4'b0, p[1][2]})) - 12'($signed({4'b0, p[1][0]}))) <<< 1)
                    + (12'($signed({4'b0, p[2][2]})) - 12'($signed({4'b0, p[2][0]})));
            n_gy[k] = (12'($signed({4'b0, p[2][0]})) - 12'($signed({4'b0, p[0][0]})))
                    + ((12'($signed({4'b0, p[2][1]})) - 12'($signed({4'b0, p[0][1]}))) <<< 1)
                    + (12'($signed({4'b0, p[2][2]})) - 12'($signed({4'b0, p[0][2]})));
        end
    end

    always_comb begin
        sx = '0;
        sy = '0;
        t  = '0;
        tt = '0;
        rr = '0;
        rr1 = '0;
        for (int k = 0; k < 3; k++) begin
            sx = r_gx[k] * r_gx[k];
            sy = r_gy[k] * r_gy[k];
            n_sq[k] = 21'(sx + sy);
            t  = r_root[k] | bitm;
            tt = t * t;
            n_root[k] = ({5'b0, tt} <= r_sq[k]) ? t : r_root[k];
            // round to nearest: bump when s exceeds r*r + r
            rr  = r_root[k] * r_root[k];
            rr1 = 17'(rr) + 17'(r_root[k]);
            if (r_sq[k] > ROOT_CLAMP_LIMIT) fin[k] = PIX_MAX;
            else if ({4'b0, rr1} < r_sq[k]) fin[k] = r_root[k] + 8'd1;
            else fin[k] = r_root[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.sum) begin
                r_gx[k] <= n_gx[k];
                r_gy[k] <= n_gy[k];
            end
            if (i_cmd.square) begin
                r_sq[k]   <= n_sq[k];
                r_root[k] <= '0;
            end else if (i_cmd.root_step) begin
                r_root[k] <= n_root[k];
            end
        end
        if (i_cmd.load_out) begin
            r_out.out_red       <= fin[0];
            r_out.out_green     <= fin[1];
            r_out.out_blue      <= fin[2];
            r_out.last_of_frame <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
endmodule

[hdl/sobel_edge_magnitude_3x3.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item that produces no result is accepted, then updates the line stores.
// An item that produces a result goes on to sums, squares, an 8-step rounded square
// root (one result bit per cycle, all three colors in parallel) and the output load.
// A finished result sits in the output register; the next item is taken
// while it waits, and only the load of the following result stalls on it.
// Reset is synchronous, active low; line stores are not cleared, since the
// row and column masks never let an unwritten entry reach a sum.
// Results lag inputs by image_width+1 items; flush items push out the tail.
module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dp_cmd    cmd;
    t_dp_status status;
    logic [$clog2(MAX_WIDTH)-1:0] addr;

    // sequencer: owns the stream position and decides masks and emission
    sem_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    // datapath: line stores, window, gradients and root
    sem_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .i_in_item   (i_in_item),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );
endmodule
